// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock, for the spanning
// tree port state update block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, switched off while reset is high.
`define STP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("spanning tree port state check failed");

// Checked at every rising edge, reset included.
`define STP_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("spanning tree port state check failed");

`endif

// File: rtl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree port state package
// Types, codes and constants shared by the port state update block.
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int NUM_PORTS_DEFAULT = 16;
   localparam int REPORTED_PORTS    = 16;

   localparam int REQ_TDATA_W = 176;
   localparam int RSP_TDATA_W = 144;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_PRIORITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_EXTENSION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_COST     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PORTS_IN_USE  = 3'd4;

   localparam logic [7:0]  OWN_PRIORITY_RESET  = 8'd128;
   localparam logic [7:0]  OWN_EXTENSION_RESET = 8'd0;
   localparam logic [47:0] OWN_MAC_RESET       = 48'd0;
   localparam logic [15:0] LINK_COST_RESET     = 16'd19;
   localparam logic [4:0]  PORTS_IN_USE_RESET  = 5'd16;

   typedef enum logic [1:0] {
      ROLE_ROOT  = 2'd0,
      ROLE_DESIG = 2'd1,
      ROLE_BLOCK = 2'd2
   } role_type;

   // First field in the lowest bits, so members are listed from the top down.
   typedef struct packed {
      logic [47:0] sender_mac;
      logic [7:0]  sender_extension;
      logic [7:0]  sender_priority;
      logic [7:0]  rx_age;
      logic [31:0] rx_path_cost;
      logic [47:0] rx_root_mac;
      logic [7:0]  rx_root_extension;
      logic [7:0]  rx_root_priority;
      logic [3:0]  arrival_port;
   } req_type;

   typedef struct packed {
      logic [7:0]  cur_message_age;
      logic [31:0] cur_root_cost;
      logic [47:0] cur_root_mac;
      logic [7:0]  cur_root_extension;
      logic [7:0]  cur_root_priority;
      logic        send_topology_notice;
      logic [31:0] port_roles;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  own_priority;
      logic [7:0]  own_extension;
      logic [47:0] own_mac;
      logic [15:0] link_cost;
      logic [4:0]  ports_in_use;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  priority_byte;
      logic [7:0]  extension_byte;
      logic [47:0] mac;
      logic [31:0] cost;
      logic [7:0]  age;
   } root_type;

endpackage

// File: rtl/stp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree configuration registers
// APB-style register bank holding this bridge's identifier, link cost and
// active port count.
// ----------------------------------------------------------------------------
module stp_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [stp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [stp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [stp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output stp_pkg::cfg_type                   cfg
);

   stp_pkg::cfg_type                 cfg_ff;
   stp_pkg::cfg_type                 cfg_in;
   logic [stp_pkg::CSR_IDX_W-1:0]    index;
   logic                             write_en;

   // Registers sit on 8-byte boundaries.
   assign index      = csr_paddr[stp_pkg::CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            stp_pkg::CSR_OWN_PRIORITY:  cfg_in.own_priority  = csr_pwdata[7:0];
            stp_pkg::CSR_OWN_EXTENSION: cfg_in.own_extension = csr_pwdata[7:0];
            stp_pkg::CSR_OWN_MAC:       cfg_in.own_mac       = csr_pwdata[47:0];
            stp_pkg::CSR_LINK_COST:     cfg_in.link_cost     = csr_pwdata[15:0];
            stp_pkg::CSR_PORTS_IN_USE:  cfg_in.ports_in_use  = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         stp_pkg::CSR_OWN_PRIORITY:  csr_prdata = 64'(cfg_ff.own_priority);
         stp_pkg::CSR_OWN_EXTENSION: csr_prdata = 64'(cfg_ff.own_extension);
         stp_pkg::CSR_OWN_MAC:       csr_prdata = 64'(cfg_ff.own_mac);
         stp_pkg::CSR_LINK_COST:     csr_prdata = 64'(cfg_ff.link_cost);
         stp_pkg::CSR_PORTS_IN_USE:  csr_prdata = 64'(cfg_ff.ports_in_use);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_priority  <= stp_pkg::OWN_PRIORITY_RESET;
         cfg_ff.own_extension <= stp_pkg::OWN_EXTENSION_RESET;
         cfg_ff.own_mac       <= stp_pkg::OWN_MAC_RESET;
         cfg_ff.link_cost     <= stp_pkg::LINK_COST_RESET;
         cfg_ff.ports_in_use  <= stp_pkg::PORTS_IN_USE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/stp_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree decision logic
// Evaluates one received BPDU against the held root and port roles and
// produces the next root record, port roles and topology notice.
// ----------------------------------------------------------------------------
module stp_decide #(
   parameter int NUM_PORTS = stp_pkg::NUM_PORTS_DEFAULT
) (
   input  stp_pkg::req_type                req,
   input  stp_pkg::cfg_type                cfg,
   input  stp_pkg::root_type               root_cur,
   input  logic [NUM_PORTS-1:0][1:0]       roles_cur,
   output stp_pkg::root_type               root_next,
   output logic [NUM_PORTS-1:0][1:0]       roles_next,
   output logic                            notice
);

   localparam int PortIdxW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int CountW   = $clog2(NUM_PORTS + 1) + 1;

   logic [63:0]               held_key, rx_key, own_key, snd_key;
   logic [32:0]               sum;
   logic [31:0]               sum_sat;
   logic                      rx_lt_held, rx_eq_held, own_lt_held, own_lt_rx, own_eq_rx;
   logic                      own_lt_snd, snd_lt_own;
   logic                      adopt, own_wins, port_ok;
   logic                      new_lt_rx, new_eq_rx;
   logic [31:0]               new_cost;
   logic [7:0]                age_inc;
   logic [PortIdxW-1:0]       port_idx;
   logic [CountW-1:0]         active_cnt;
   logic [NUM_PORTS-1:0][1:0] roles_mid;
   stp_pkg::role_type         role;

   assign held_key = {root_cur.priority_byte, root_cur.extension_byte, root_cur.mac};
   assign rx_key   = {req.rx_root_priority, req.rx_root_extension, req.rx_root_mac};
   assign own_key  = {cfg.own_priority, cfg.own_extension, cfg.own_mac};
   assign snd_key  = {req.sender_priority, req.sender_extension, req.sender_mac};

   assign sum     = {1'b0, req.rx_path_cost} + {17'd0, cfg.link_cost};
   assign sum_sat = sum[32] ? '1 : sum[31:0];
   assign age_inc = (req.rx_age == 8'hFF) ? 8'hFF : req.rx_age + 8'd1;

   // All key compares run side by side; the outcome is then picked by flags.
   assign rx_lt_held  = rx_key < held_key;
   assign rx_eq_held  = rx_key == held_key;
   assign own_lt_held = own_key < held_key;
   assign own_lt_rx   = own_key < rx_key;
   assign own_eq_rx   = own_key == rx_key;
   assign own_lt_snd  = own_key < snd_key;
   assign snd_lt_own  = snd_key < own_key;

   assign adopt    = rx_lt_held || (rx_eq_held && (sum_sat < root_cur.cost));
   assign own_wins = adopt ? own_lt_rx : own_lt_held;
   assign notice   = adopt;

   always_comb begin
      if (own_wins) begin
         new_lt_rx = own_lt_rx;
         new_eq_rx = own_eq_rx;
      end else if (adopt) begin
         new_lt_rx = 1'b0;
         new_eq_rx = 1'b1;
      end else begin
         new_lt_rx = !rx_lt_held && !rx_eq_held;
         new_eq_rx = rx_eq_held;
      end
   end

   assign new_cost = own_wins ? 32'd0 : (adopt ? sum_sat : root_cur.cost);

   always_comb begin
      root_next = root_cur;
      if (adopt) begin
         root_next.priority_byte  = req.rx_root_priority;
         root_next.extension_byte = req.rx_root_extension;
         root_next.mac            = req.rx_root_mac;
         root_next.age            = age_inc;
      end
      if (own_wins) begin
         root_next.priority_byte  = cfg.own_priority;
         root_next.extension_byte = cfg.own_extension;
         root_next.mac            = cfg.own_mac;
      end
      root_next.cost = new_cost;
   end

   assign port_ok    = CountW'(req.arrival_port) < CountW'(NUM_PORTS);
   assign port_idx   = PortIdxW'(req.arrival_port);
   assign active_cnt = CountW'(cfg.ports_in_use);

   // Root demotion and own-root sweep over the active ports, plus new root port.
   always_comb begin
      for (int i = 0; i < NUM_PORTS; i++) begin
         roles_mid[i] = roles_cur[i];
         if (adopt && (CountW'(i) < active_cnt) && (roles_cur[i] == stp_pkg::ROLE_ROOT)) begin
            roles_mid[i] = stp_pkg::ROLE_DESIG;
         end
         if (adopt && (CountW'(i) == CountW'(req.arrival_port))) begin
            roles_mid[i] = stp_pkg::ROLE_ROOT;
         end
         if (own_wins && (CountW'(i) < active_cnt)) begin
            roles_mid[i] = stp_pkg::ROLE_DESIG;
         end
      end
   end

   // The arrival port then moves between designated and blocking.
   always_comb begin
      role = port_ok ? stp_pkg::role_type'(roles_mid[port_idx]) : stp_pkg::ROLE_DESIG;
      if (role == stp_pkg::ROLE_BLOCK) begin
         if (new_lt_rx) begin
            role = stp_pkg::ROLE_DESIG;
         end
         if (new_eq_rx && ((new_cost < req.rx_path_cost) ||
                           ((new_cost == req.rx_path_cost) && own_lt_snd))) begin
            role = stp_pkg::ROLE_DESIG;
         end
      end
      if (role == stp_pkg::ROLE_DESIG) begin
         if (new_eq_rx && ((new_cost > req.rx_path_cost) ||
                           ((new_cost == req.rx_path_cost) && snd_lt_own))) begin
            role = stp_pkg::ROLE_BLOCK;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_PORTS; i++) begin
         roles_next[i] = (CountW'(i) == CountW'(req.arrival_port)) ? role : roles_mid[i];
      end
   end

endmodule

// File: rtl/spanning_tree_port_state_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree port state update
// Takes one received BPDU per request and updates the held root bridge, the
// root path cost, the message age and the role of every port.
// ----------------------------------------------------------------------------
// A new request is accepted in every clock cycle while the response side keeps
// up. The request is captured in an input register and evaluated against the
// held state by a single combinational pass (all identifier compares run in
// parallel). The updated state and its response are written when the staged
// request advances, that is when the response register is free or is being
// emptied. The held state is updated in the same edge as the response
// register, so the next request always sees the effect of the one before it.
// While a response waits to be taken, the input register can still take one
// more request; with both registers full, req_tready stays low until the
// response is taken. req_tready follows rsp_tready in the same cycle, so a
// response and a new request can be taken at the same edge.
// Configuration writes are expected only while no request is in flight.
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module spanning_tree_port_state_update #(
   parameter int NUM_PORTS = stp_pkg::NUM_PORTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lowest bits first: arrival_port(4), rx_root_priority(8),
   // rx_root_extension(8), rx_root_mac(48), rx_path_cost(32), rx_age(8),
   // sender_priority(8), sender_extension(8), sender_mac(48), zero fill(4).
   input  logic [stp_pkg::REQ_TDATA_W-1:0]    req_tdata,

   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata, lowest bits first: port_roles(32), send_topology_notice(1),
   // cur_root_priority(8), cur_root_extension(8), cur_root_mac(48),
   // cur_root_cost(32), cur_message_age(8), zero fill(7).
   output logic [stp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,

   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [stp_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [stp_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [stp_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   stp_pkg::cfg_type          cfg;

   // Input register: the request waiting for evaluation.
   logic                      stage_vld_ff, stage_vld_in;
   stp_pkg::req_type          stage_ff;
   logic                      advance;

   // Held protocol state.
   stp_pkg::root_type         root_ff, root_in;
   logic [NUM_PORTS-1:0][1:0] roles_ff, roles_in;
   logic                      notice;

   // Response register.
   logic                      rsp_vld_ff, rsp_vld_in;
   stp_pkg::rsp_type          rsp_ff, rsp_in;

   logic [stp_pkg::REPORTED_PORTS-1:0][1:0] roles_report;
   logic                      role_code_bad;

   stp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   stp_decide #(
      .NUM_PORTS (NUM_PORTS)
   ) u_decide (
      .req        (stage_ff),
      .cfg        (cfg),
      .root_cur   (root_ff),
      .roles_cur  (roles_ff),
      .root_next  (root_in),
      .roles_next (roles_in),
      .notice     (notice)
   );

   // The staged request moves on whenever the response register is free or
   // is being emptied in this cycle; the input register refills behind it.
   assign advance      = stage_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready   = !stage_vld_ff || advance;
   assign stage_vld_in = (req_tvalid && req_tready) || (stage_vld_ff && !advance);
   assign rsp_vld_in   = advance || (rsp_vld_ff && !rsp_tready);

   // Only the first sixteen ports fit in the reported role field; slots of
   // ports beyond NUM_PORTS read as zero.
   for (genvar g = 0; g < stp_pkg::REPORTED_PORTS; g++) begin : g_report
      if (g < NUM_PORTS) begin : g_used
         assign roles_report[g] = roles_in[g];
      end else begin : g_unused
         assign roles_report[g] = 2'b00;
      end
   end

   always_comb begin
      rsp_in.port_roles           = roles_report;
      rsp_in.send_topology_notice = notice;
      rsp_in.cur_root_priority    = root_in.priority_byte;
      rsp_in.cur_root_extension   = root_in.extension_byte;
      rsp_in.cur_root_mac         = root_in.mac;
      rsp_in.cur_root_cost        = root_in.cost;
      rsp_in.cur_message_age      = root_in.age;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff          <= 1'b0;
         rsp_vld_ff            <= 1'b0;
         root_ff.priority_byte  <= '1;
         root_ff.extension_byte <= '1;
         root_ff.mac            <= '1;
         root_ff.cost           <= '1;
         root_ff.age            <= '0;
         roles_ff              <= {NUM_PORTS{2'(stp_pkg::ROLE_DESIG)}};
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
         if (advance) begin
            root_ff  <= root_in;
            roles_ff <= roles_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff <= stp_pkg::req_type'(req_tdata[$bits(stp_pkg::req_type)-1:0]);
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(stp_pkg::RSP_TDATA_W - $bits(stp_pkg::rsp_type))'(0), rsp_ff};

   // No role slot may ever hold the unused fourth code.
   always_comb begin
      role_code_bad = 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         role_code_bad = role_code_bad | (&roles_ff[i]);
      end
   end

   // Reset leaves every port designated.
   `STP_ASSERT_ALWAYS(a_reset_roles, reset |=> (roles_ff == {NUM_PORTS{2'(stp_pkg::ROLE_DESIG)}}))
   // Held state changes only when a request is evaluated.
   `STP_ASSERT(a_state_holds, !advance |=> ($stable(root_ff) && $stable(roles_ff)))
   // Role codes stay within root, designated and blocking.
   `STP_ASSERT(a_role_codes, !role_code_bad)
   // A request evaluated leaves a response pending in the next cycle.
   `STP_ASSERT(a_rsp_follows, advance |=> rsp_vld_ff)

endmodule

// File: sim/tb_spanning_tree_port_state_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spanning tree port state update testbench
// Sends received BPDUs into the block over its request stream. A scoreboard
// holds its own copy of the root, cost, age and port roles. It works out the
// state update that each accepted request should give and compares each
// response with it, field by field. The configuration is written over the
// register port between phases, and both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------

import stp_pkg::*;

// Keeps the expected bridge state and the queue of updates still to come.
class port_state_scoreboard;
   localparam int PORT_COUNT = NUM_PORTS_DEFAULT;

   cfg_type  regs;
   root_type best;
   role_type port_role [PORT_COUNT];
   rsp_type  awaited_updates [$];
   int       errors;

   function new();
      regs.own_priority  = OWN_PRIORITY_RESET;
      regs.own_extension = OWN_EXTENSION_RESET;
      regs.own_mac       = OWN_MAC_RESET;
      regs.link_cost     = LINK_COST_RESET;
      regs.ports_in_use  = PORTS_IN_USE_RESET;
      best.priority_byte  = '1;
      best.extension_byte = '1;
      best.mac            = '1;
      best.cost           = '1;
      best.age            = '0;
      foreach (port_role[i]) port_role[i] = ROLE_DESIG;
      errors = 0;
   endfunction

   function logic [63:0] root_id();
      return {best.priority_byte, best.extension_byte, best.mac};
   endfunction

   function void set_register(input logic [CSR_IDX_W-1:0] slot,
                              input logic [CSR_DATA_W-1:0] value);
      case (slot)
         CSR_OWN_PRIORITY:  regs.own_priority  = value[7:0];
         CSR_OWN_EXTENSION: regs.own_extension = value[7:0];
         CSR_OWN_MAC:       regs.own_mac       = value[47:0];
         CSR_LINK_COST:     regs.link_cost     = value[15:0];
         CSR_PORTS_IN_USE:  regs.ports_in_use  = value[4:0];
         default: ;
      endcase
   endfunction

   // Applies one accepted BPDU to the held state and queues the response.
   function void note_bpdu(input req_type r);
      logic [63:0] rx_id, sender_id, own_id;
      logic [32:0] total;
      logic [31:0] offered_cost;
      int          active;
      role_type    role;
      rsp_type     want;
      rx_id     = {r.rx_root_priority, r.rx_root_extension, r.rx_root_mac};
      sender_id = {r.sender_priority, r.sender_extension, r.sender_mac};
      own_id    = {regs.own_priority, regs.own_extension, regs.own_mac};
      total     = {1'b0, r.rx_path_cost} + {17'b0, regs.link_cost};
      offered_cost = total[32] ? '1 : total[31:0];
      active = (regs.ports_in_use > PORT_COUNT) ? PORT_COUNT : int'(regs.ports_in_use);
      want.send_topology_notice = 1'b0;

      // A better root, or the held root over a cheaper path, is adopted.
      if (rx_id < root_id() || (rx_id == root_id() && offered_cost < best.cost)) begin
         best.priority_byte  = r.rx_root_priority;
         best.extension_byte = r.rx_root_extension;
         best.mac            = r.rx_root_mac;
         best.cost           = offered_cost;
         best.age            = (r.rx_age == 8'hFF) ? 8'hFF : r.rx_age + 8'd1;
         for (int i = 0; i < active; i++)
            if (port_role[i] == ROLE_ROOT) port_role[i] = ROLE_DESIG;
         port_role[r.arrival_port] = ROLE_ROOT;
         want.send_topology_notice = 1'b1;
      end

      // This bridge takes over as root; the message age is left alone.
      if (own_id < root_id()) begin
         best.priority_byte  = regs.own_priority;
         best.extension_byte = regs.own_extension;
         best.mac            = regs.own_mac;
         best.cost           = '0;
         for (int i = 0; i < active; i++) port_role[i] = ROLE_DESIG;
      end

      role = port_role[r.arrival_port];
      if (role == ROLE_BLOCK) begin
         if (root_id() < rx_id)
            role = ROLE_DESIG;
         if (root_id() == rx_id && (best.cost < r.rx_path_cost ||
             (best.cost == r.rx_path_cost && own_id < sender_id)))
            role = ROLE_DESIG;
      end
      if (role == ROLE_DESIG && rx_id == root_id() && (best.cost > r.rx_path_cost ||
          (best.cost == r.rx_path_cost && own_id > sender_id)))
         role = ROLE_BLOCK;
      port_role[r.arrival_port] = role;

      want.port_roles = '0;
      for (int i = 0; i < PORT_COUNT && i < REPORTED_PORTS; i++)
         want.port_roles[2*i +: 2] = port_role[i];
      want.cur_root_priority  = best.priority_byte;
      want.cur_root_extension = best.extension_byte;
      want.cur_root_mac       = best.mac;
      want.cur_root_cost      = best.cost;
      want.cur_message_age    = best.age;
      awaited_updates.push_back(want);
   endfunction

   function void compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_update(input rsp_type got);
      rsp_type want;
      if (awaited_updates.size() == 0) begin
         $error("response with no request outstanding");
         errors++;
         return;
      end
      want = awaited_updates.pop_front();
      compare_field("port_roles", want.port_roles, got.port_roles);
      compare_field("send_topology_notice", want.send_topology_notice,
                    got.send_topology_notice);
      compare_field("cur_root_priority", want.cur_root_priority, got.cur_root_priority);
      compare_field("cur_root_extension", want.cur_root_extension, got.cur_root_extension);
      compare_field("cur_root_mac", want.cur_root_mac, got.cur_root_mac);
      compare_field("cur_root_cost", want.cur_root_cost, got.cur_root_cost);
      compare_field("cur_message_age", want.cur_message_age, got.cur_message_age);
   endfunction
endclass

module tb_spanning_tree_port_state_update;

   // Random requests in each configuration phase, after the opening sequence.
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 65;
   // Length of the deliberate response hold-off, in clock cycles.
   localparam int LONG_HOLD       = 80;
   // Bridge identifier that the block holds after reset.
   localparam logic [63:0] OWN_ID_AT_RESET =
      {OWN_PRIORITY_RESET, OWN_EXTENSION_RESET, OWN_MAC_RESET};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // tdata, lowest bits first: arrival_port, rx_root_priority,
   // rx_root_extension, rx_root_mac, rx_path_cost, rx_age, sender_priority,
   // sender_extension, sender_mac, zero fill.
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // tdata, lowest bits first: port_roles, send_topology_notice,
   // cur_root_priority, cur_root_extension, cur_root_mac, cur_root_cost,
   // cur_message_age, zero fill.
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Set when both stream sides should run without any idling.
   bit steady_flow  = 1'b0;
   // Raised by the stimulus to make the receiver hold off for a long stretch.
   bit hold_request = 1'b0;

   port_state_scoreboard board = new();

   spanning_tree_port_state_update dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every handshake is observed at the rising edge. Inputs only move on the
   // falling edge, so the values seen here are the ones the block sampled.
   // Requests are noted before responses are checked, although a response never
   // belongs to the request of its own edge, still held in the input register.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            board.set_register(csr_paddr[CSR_ADDR_W-1:3], csr_pwdata);
         if (req_tvalid && req_tready)
            board.note_bpdu(req_type'(req_tdata[$bits(req_type)-1:0]));
         if (rsp_tvalid && rsp_tready)
            board.check_update(rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type bpdu(input logic [3:0] port, input logic [63:0] root_id,
                                    input logic [31:0] cost, input logic [7:0] age,
                                    input logic [63:0] sender_id);
      req_type r;
      r.arrival_port = port;
      {r.rx_root_priority, r.rx_root_extension, r.rx_root_mac} = root_id;
      r.rx_path_cost = cost;
      r.rx_age       = age;
      {r.sender_priority, r.sender_extension, r.sender_mac} = sender_id;
      return r;
   endfunction

   // Random BPDUs are steered towards the currently held root and this
   // bridge's own identifier, so that the tie breaks on cost and on the
   // sender's identifier are reached often; a share stays fully random.
   function automatic req_type random_bpdu();
      logic [63:0] held, own, root_id, sender_id;
      logic [31:0] cost;
      logic [7:0]  age;
      int          roll;
      held = board.root_id();
      own  = {board.regs.own_priority, board.regs.own_extension, board.regs.own_mac};

      roll = $urandom_range(0, 9);
      if (roll < 5)
         root_id = held;
      else if (roll < 7)
         root_id = (held > 64'd3) ? held - 64'($urandom_range(1, 3)) : held;
      else if (roll == 7)
         root_id = (held < 64'hFFFF_FFFF_FFFF_FFFC) ? held + 64'($urandom_range(1, 3)) : held;
      else if (roll == 8)
         root_id = own;
      else
         root_id = {$urandom, $urandom};

      roll = $urandom_range(0, 9);
      if (roll < 5)
         cost = $urandom_range(0, 60);
      else if (roll < 7)
         cost = board.best.cost + 32'($urandom_range(0, 4)) - 32'd2;
      else if (roll == 7)
         cost = $urandom;
      else
         cost = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));

      roll = $urandom_range(0, 9);
      if (roll == 0)
         age = 8'hFF;
      else if (roll == 1)
         age = 8'hFE;
      else
         age = 8'($urandom);

      roll = $urandom_range(0, 9);
      if (roll < 4)
         sender_id = own;
      else if (roll == 4)
         sender_id = own + 64'd1;
      else if (roll == 5)
         sender_id = own - 64'd1;
      else
         sender_id = {$urandom, $urandom};

      return bpdu(4'($urandom_range(0, 15)), root_id, cost, age, sender_id);
   endfunction

   // Settings per phase. The first phases take the extremes of the
   // identifier, the link cost and the active port count (none, one, and
   // more than the block has). The own identifier of all zeros comes last,
   // because once the bridge is root with cost zero nothing can displace it.
   function automatic cfg_type settings_for_phase(input int phase);
      cfg_type     c;
      logic [63:0] held;
      c.own_priority  = 8'($urandom);
      c.own_extension = 8'($urandom);
      c.own_mac       = 48'({$urandom, $urandom});
      c.link_cost     = 16'($urandom);
      c.ports_in_use  = 5'($urandom_range(2, 15));
      case (phase)
         0: begin
            {c.own_priority, c.own_extension, c.own_mac} = '1;
            c.link_cost    = '0;
            c.ports_in_use = 5'd16;
         end
         1: begin
            c.link_cost    = '1;
            c.ports_in_use = 5'd0;
         end
         2: begin
            // Just better than the held root, so the bridge takes over.
            held = board.root_id();
            {c.own_priority, c.own_extension, c.own_mac} = (held != '0) ? held - 64'd1 : held;
            c.ports_in_use = 5'd31;
         end
         3: begin
            c.link_cost    = 16'd19;
            c.ports_in_use = 5'd1;
         end
         5: begin
            {c.own_priority, c.own_extension, c.own_mac} = '0;
            c.ports_in_use = 5'd9;
         end
         default: ;
      endcase
      return c;
   endfunction

   // Offers one request and returns on the falling edge after its acceptance,
   // with valid still high so that a following request can go straight on.
   task automatic offer_bpdu(input req_type r);
      req_tdata  <= REQ_TDATA_W'(r);
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic sender_pause();
      int gap;
      if (!steady_flow && $urandom_range(0, 1) == 1) begin
         gap = pick_gap();
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops sending and waits for every outstanding response, then lets the
   // block's input and response registers settle before anything else happens.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.awaited_updates.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes all five registers back to back; psel stays high between them.
   task automatic write_settings(input cfg_type c);
      logic [CSR_IDX_W-1:0]  slot  [5];
      logic [CSR_DATA_W-1:0] value [5];
      slot  = '{CSR_OWN_PRIORITY, CSR_OWN_EXTENSION, CSR_OWN_MAC,
                CSR_LINK_COST, CSR_PORTS_IN_USE};
      value = '{CSR_DATA_W'(c.own_priority), CSR_DATA_W'(c.own_extension),
                CSR_DATA_W'(c.own_mac), CSR_DATA_W'(c.link_cost),
                CSR_DATA_W'(c.ports_in_use)};
      for (int i = 0; i < 5; i++) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {slot[i], 3'b000};
         csr_pwdata  <= value[i];
         @(negedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         @(negedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Receiver: random stalls of varying length, none while the flow is
   // steady, and one long hold-off on request so that the block fills up and
   // pushes back on its request side.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   initial begin
      req_type opening [$];
      cfg_type settings;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening sequence under the reset settings (own identifier 128:0:0,
      // link cost 19, all sixteen ports active).
      // A root worse than this bridge is taken first, and then this bridge
      // takes over as root, so all ports fall back to designated.
      opening.push_back(bpdu(4'd4, 64'hC800_0000_0000_0000, 32'd10, 8'd3, 64'h1234_5678));
      // A better root over a maximal cost: the cost sum saturates and the
      // age of 255 stays at 255.
      opening.push_back(bpdu(4'd2, 64'h4000_0000_0000_0005, 32'hFFFF_FFFF, 8'hFF, '0));
      // Same root more cheaply on another port: the old root port is demoted.
      opening.push_back(bpdu(4'd7, 64'h4000_0000_0000_0005, 32'd0, 8'hFE, '1));
      // A neighbour closer to the root blocks the port, a farther one frees it.
      opening.push_back(bpdu(4'd3, 64'h4000_0000_0000_0005, 32'd0, 8'd0, '1));
      opening.push_back(bpdu(4'd3, 64'h4000_0000_0000_0005, 32'd40, 8'd9, '1));
      // Equal cost: the bridge identifiers break the tie either way, and an
      // equal identifier leaves the port as it is.
      opening.push_back(bpdu(4'd5, 64'h4000_0000_0000_0005, 32'd19, 8'd1, 64'd1));
      opening.push_back(bpdu(4'd5, 64'h4000_0000_0000_0005, 32'd19, 8'd1, '1));
      opening.push_back(bpdu(4'd6, 64'h4000_0000_0000_0005, 32'd19, 8'd1, OWN_ID_AT_RESET));
      // Every field at its maximum: a worse root on the highest port.
      opening.push_back(bpdu(4'd15, '1, '1, '1, '1));
      // A better root on port 0 moves the root port once more.
      opening.push_back(bpdu(4'd0, 64'h2000_0000_0000_0000, 32'd0, 8'd0, '0));
      // Block a port, then unblock it with a root worse than the held one.
      opening.push_back(bpdu(4'd5, 64'h2000_0000_0000_0000, 32'd5, 8'd7, '1));
      opening.push_back(bpdu(4'd5, 64'h3000_0000_0000_0000, 32'd5, 8'd7, '1));
      foreach (opening[i]) begin
         offer_bpdu(opening[i]);
         sender_pause();
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // The registers only change with nothing in flight.
         wait_drained();
         settings = settings_for_phase(phase);
         write_settings(settings);
         steady_flow = (phase == 1 || phase == 4);
         // While the receiver holds off, the sender keeps offering requests
         // back to back, so the block's buffering fills and it stalls.
         if (phase == 1) hold_request = 1'b1;
         // Every field at zero, while a root of zero is still new to the block.
         if (phase == PHASES - 1) offer_bpdu(bpdu('0, '0, '0, '0, '0));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            offer_bpdu(random_bpdu());
            sender_pause();
         end
      end

      wait_drained();
      if (board.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // A correct run takes well under a millisecond even with the longest
   // gaps on both sides; anything far beyond that is a hang.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: spanning_tree_port_state_update.f
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_csr.sv
rtl/stp_decide.sv
rtl/spanning_tree_port_state_update.sv
sim/tb_spanning_tree_port_state_update.sv
